// File: rtl/tswr_pkg.sv
// shared types and constants for the tcp sender window and retransmit unit
package tswr_pkg;

	localparam logic [1:0] OP_SEND  = 2'd0;
	localparam logic [1:0] OP_ACK   = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_PROBE = 2'd3;

	localparam logic CFG_ISN = 1'b0;
	localparam logic CFG_RTO = 1'b1;

	localparam logic [16:0] FLIGHT_MAX = 17'h1ffff;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] bytes_available;
		logic        stream_finished;
		logic        stream_error;
		logic        ack_valid;
		logic [31:0] ack_number;
		logic [15:0] adv_window;
		logic        peer_reset;
		logic [31:0] elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic        segment_valid;
		logic        is_retransmission;
		logic [31:0] segment_seqno;
		logic        syn_flag;
		logic        fin_flag;
		logic        reset_flag;
		logic [9:0]  payload_length;
		logic [16:0] in_flight_count;
		logic [7:0]  retry_count;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEND,
		ST_ACK_RD,
		ST_ACK_CHK,
		ST_TICK_RD,
		ST_TICK_CHK,
		ST_DONE
	} state_t;

endpackage

// File: rtl/tswr_ram.sv
// generic single write port ram with registered read
module tswr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/tcp_sender_window_retransmit_unit.sv
// tcp sender control block: sliding window, segment queue and retransmit timer
// One operation gives one result. Send-next runs through decode, send and done,
// probe through decode and done. An ack without ackno or with RST goes from decode
// to done, else it loops on a queue ram read and a check per popped segment, paced
// by the ram read port. Tick reads and checks the head, or goes straight to done
// with an empty queue. The result sits in an output register until taken, and the
// next operation is accepted only in the cycle after it has been.
module tcp_sender_window_retransmit_unit #(
	parameter int MAX_PAYLOAD = 1000,
	parameter int QUEUE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tswr_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tswr_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata
);
	import tswr_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int AW1 = AW + 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [10:0] MAXP = 11'(MAX_PAYLOAD);
	localparam logic [AW:0] DEPTH_W = AW1'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

	state_t state_q, state_d;
	in_item_t item_q;
	out_item_t res_q;
	out_item_t dec_res;
	logic res_valid_q;

	logic [31:0] isn_q;
	logic [15:0] rto_init_q;
	logic [63:0] nxt_q;
	logic [16:0] win_q;
	logic [16:0] flight_q;
	logic [7:0]  retries_q;
	logic [31:0] rto_q;
	logic [31:0] elapsed_q;
	logic        err_q, fin_sent_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [63:0] abs_ack_q;

	// queue ram: start in 64 bits, info = fin, syn, length
	logic          q_we;
	logic [AW-1:0] q_waddr;
	logic [AW:0]   q_wsum;
	logic [76:0]   q_wdata, q_rdata;
	logic [63:0]   rd_start;
	logic [10:0]   rd_len;
	logic          rd_syn, rd_fin;

	tswr_ram #(.WIDTH(77), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q), .rdata(q_rdata)
	);
	assign rd_start = q_rdata[76:13];
	assign rd_fin   = q_rdata[12];
	assign rd_syn   = q_rdata[11];
	assign rd_len   = q_rdata[10:0];

	// send path
	logic        s_syn, s_fin;
	logic [16:0] s_win, s_room, s_len, s_total;
	logic [16:0] avail17;
	always_comb begin
		avail17 = {1'b0, item_q.bytes_available};
		s_syn = (nxt_q == 64'd0);
		s_win = (win_q == 17'd0 && flight_q == 17'd0) ? 17'd1 : win_q;
		s_room = (s_syn && s_win != 17'd0) ? s_win - 17'd1 : s_win;
		s_len = {6'd0, MAXP};
		if (avail17 < s_len) s_len = avail17;
		if (s_room < s_len) s_len = s_room;
		s_fin = !fin_sent_q && item_q.stream_finished && avail17 == s_len
			&& (s_room - s_len) != 17'd0;
		s_total = {16'd0, s_syn} + s_len + {16'd0, s_fin};
	end

	// ack unwrap, computed once per ack
	logic [63:0] u_cand, u_res;
	logic [31:0] u_off;
	always_comb begin
		u_off = item_q.ack_number - isn_q;
		u_cand = {nxt_q[63:32], u_off};
		u_res = u_cand;
		if (u_cand > nxt_q) begin
			if ((u_cand - nxt_q) > 64'h8000_0000 && u_cand[63:32] != 32'd0)
				u_res = u_cand - 64'h1_0000_0000;
		end else if ((nxt_q - u_cand) > 64'h8000_0000 && u_cand[63:32] != 32'hffff_ffff)
			u_res = u_cand + 64'h1_0000_0000;
	end

	// probe result, all zero for the other operations
	always_comb begin
		dec_res = '0;
		if (item_q.operation == OP_PROBE) begin
			dec_res.segment_valid = 1'b1;
			dec_res.segment_seqno = nxt_q[31:0] + isn_q;
			dec_res.reset_flag = item_q.stream_error || err_q;
		end
	end

	logic [16:0] seg_l;
	logic        pop_ok;
	logic [32:0] t_sum;
	always_comb begin
		seg_l = {6'd0, rd_len} + {16'd0, rd_syn} + {16'd0, rd_fin};
		pop_ok = count_q != '0 && abs_ack_q <= nxt_q
			&& (rd_start + {47'd0, seg_l}) <= abs_ack_q;
		t_sum = {1'b0, item_q.elapsed_ms} + {1'b0, elapsed_q};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid && in_ready) state_d = ST_DECODE;
			ST_DECODE: begin
				unique case (item_q.operation)
					OP_SEND:  state_d = ST_SEND;
					OP_ACK:   state_d = (item_q.peer_reset || !item_q.ack_valid)
						? ST_DONE : ST_ACK_RD;
					OP_TICK:  state_d = (count_q == '0) ? ST_DONE : ST_TICK_RD;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_SEND:     state_d = ST_DONE;
			ST_ACK_RD:   state_d = ST_ACK_CHK;
			ST_ACK_CHK:  state_d = pop_ok ? ST_ACK_RD : ST_DONE;
			ST_TICK_RD:  state_d = ST_TICK_CHK;
			ST_TICK_CHK: state_d = ST_DONE;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE) && !res_valid_q;
		out_valid = res_valid_q;
		out_data = res_q;
		q_we = (state_q == ST_SEND) && count_q < CW'(QUEUE_DEPTH) && s_total != 17'd0;
		// tail slot, wrapped by one compare and subtract
		q_wsum = {1'b0, head_q} + AW1'(count_q);
		q_waddr = (q_wsum >= DEPTH_W) ? AW'(q_wsum - DEPTH_W) : q_wsum[AW-1:0];
		q_wdata = {nxt_q, s_fin, s_syn, s_len[10:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_q <= '0;
			abs_ack_q <= '0;
			isn_q <= '0;
			rto_init_q <= 16'd1000;
			nxt_q <= '0;
			win_q <= 17'd1;
			flight_q <= '0;
			retries_q <= '0;
			rto_q <= 32'd1000;
			elapsed_q <= '0;
			err_q <= 1'b0;
			fin_sent_q <= 1'b0;
			head_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ISN: isn_q <= cfg_wdata;
					CFG_RTO: begin
						rto_init_q <= cfg_wdata[15:0];
						rto_q <= {16'd0, cfg_wdata[15:0]};
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_DECODE: begin
					res_q <= dec_res;
					if (item_q.operation == OP_ACK && !item_q.peer_reset)
						win_q <= {1'b0, item_q.adv_window};
					if (item_q.operation == OP_ACK && item_q.peer_reset)
						err_q <= 1'b1;
					abs_ack_q <= u_res;
				end
				ST_SEND: begin
					if (count_q < CW'(QUEUE_DEPTH)) begin
						if (s_total != 17'd0) begin
							res_q.segment_valid <= 1'b1;
							res_q.segment_seqno <= nxt_q[31:0] + isn_q;
							res_q.syn_flag <= s_syn;
							res_q.fin_flag <= s_fin;
							res_q.reset_flag <= item_q.stream_error || err_q;
							res_q.payload_length <= s_len[9:0];
							count_q <= count_q + 1'b1;
							nxt_q <= nxt_q + {47'd0, s_total};
							win_q <= (s_win >= s_total) ? s_win - s_total : 17'd0;
							flight_q <= ({1'b0, flight_q} + {1'b0, s_total} > {1'b0, FLIGHT_MAX})
								? FLIGHT_MAX : flight_q + s_total;
							if (s_fin) fin_sent_q <= 1'b1;
						end else
							win_q <= s_win;
					end
				end
				ST_ACK_CHK: begin
					if (pop_ok) begin
						flight_q <= (flight_q >= seg_l) ? flight_q - seg_l : 17'd0;
						head_q <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
						count_q <= count_q - 1'b1;
						retries_q <= '0;
						rto_q <= {16'd0, rto_init_q};
						elapsed_q <= '0;
					end
				end
				ST_TICK_CHK: begin
					if (t_sum >= {1'b0, rto_q}) begin
						elapsed_q <= '0;
						if (win_q != 17'd0) begin
							rto_q <= rto_q[31] ? 32'hffff_ffff : {rto_q[30:0], 1'b0};
							if (retries_q != 8'hff) retries_q <= retries_q + 1'b1;
						end
						res_q.segment_valid <= 1'b1;
						res_q.is_retransmission <= 1'b1;
						res_q.segment_seqno <= rd_start[31:0] + isn_q;
						res_q.payload_length <= rd_len[9:0];
						res_q.syn_flag <= rd_syn;
						res_q.fin_flag <= rd_fin;
						res_q.reset_flag <= item_q.stream_error || err_q;
					end else
						elapsed_q <= t_sum[32] ? 32'hffff_ffff : t_sum[31:0];
				end
				ST_DONE: begin
					res_q.in_flight_count <= flight_q;
					res_q.retry_count <= retries_q;
					res_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_data;
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_done_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid) else $error("result lost");
	a_empty_no_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q == '0) |-> flight_q == 17'd0)
		else $error("flight without queue");
`endif
endmodule
